>>> rtl/wpt_pkg.sv
// ============================================================================
// wpt_pkg: shared definitions for the weighted pick-and-remove table
// Widths, operation and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ============================================================================
package wpt_pkg;

   // Table geometry.
   localparam int DEPTH     = 64;
   localparam int DATA_BITS = 32;

   // Field widths of the request and response words.
   localparam int FUNC_BITS      = 2;
   localparam int ITEM_DATA_BITS = 32;
   localparam int WEIGHT_BITS    = 16;
   localparam int INDEX_BITS     = 22;
   localparam int STATUS_BITS    = 2;
   localparam int TOTAL_BITS     = 22;
   localparam int HELD_BITS      = 7;

   // Derived internal widths.
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int SUM_BITS  = WEIGHT_BITS + CNT_BITS;
   localparam int CMP_BITS  = (SUM_BITS > INDEX_BITS) ? SUM_BITS : INDEX_BITS;

   // Saturation limits of the reported totals.
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [HELD_BITS-1:0]  HELD_MAX  = '1;

   // Operation codes.
   localparam logic [FUNC_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [FUNC_BITS-1:0] OP_PICK   = 2'd1;
   localparam logic [FUNC_BITS-1:0] OP_CLEAR  = 2'd2;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOMATCH = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic take;     // latch the request word and start a new operation
      logic walk;     // scan entries, accumulating weights
      logic shift;    // move later entries down over the removed one
      logic finish;   // update totals and load the response register
   } wpt_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic walk_hit;
      logic walk_miss;
      logic shift_done;
      logic out_free;
   } wpt_stat_type;

endpackage

>>> rtl/wpt_req_if.sv
// ============================================================================
// wpt_req_if: request channel of the weighted pick-and-remove table
// Valid/ready channel carrying one operation word.
// ============================================================================
interface wpt_req_if import wpt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_BITS-1:0]      func;
   logic [ITEM_DATA_BITS-1:0] item_data;
   logic [WEIGHT_BITS-1:0]    item_weight;
   logic [INDEX_BITS-1:0]     pick_index;

   modport source (output valid, output func, output item_data, output item_weight,
                   output pick_index, input ready);
   modport sink   (input valid, input func, input item_data, input item_weight,
                   input pick_index, output ready);
endinterface

>>> rtl/wpt_rsp_if.sv
// ============================================================================
// wpt_rsp_if: response channel of the weighted pick-and-remove table
// Valid/ready channel carrying one result word.
// ============================================================================
interface wpt_rsp_if import wpt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_BITS-1:0]    status;
   logic [ITEM_DATA_BITS-1:0] picked_data;
   logic [WEIGHT_BITS-1:0]    taken_weight;
   logic [TOTAL_BITS-1:0]     total_weight;
   logic [HELD_BITS-1:0]      entries_held;

   modport source (output valid, output status, output picked_data, output taken_weight,
                   output total_weight, output entries_held, input ready);
   modport sink   (input valid, input status, input picked_data, input taken_weight,
                   input total_weight, input entries_held, output ready);
endinterface

>>> rtl/wpt_controller.sv
// ============================================================================
// wpt_controller: sequencer of the weighted pick-and-remove table
// Steps one operation at a time through scan, shift and response phases.
// ============================================================================
module wpt_controller import wpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [FUNC_BITS-1:0] req_func,
   output logic                 req_ready,
   output wpt_cmd_type          cmd,
   input  wpt_stat_type         stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = (req_func == OP_PICK) ? S_WALK : S_DONE;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_hit) begin
               state_in = S_SHIFT;
            end else if (stat.walk_miss) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/wpt_datapath.sv
// ============================================================================
// wpt_datapath: table storage, running sum and result register
// Holds the entry memory, the count and weight total, the scan pointer and
// the response register.
// ============================================================================
module wpt_datapath import wpt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  wpt_cmd_type               cmd,
   output wpt_stat_type              stat,
   input  logic [FUNC_BITS-1:0]      req_func,
   input  logic [ITEM_DATA_BITS-1:0] req_item_data,
   input  logic [WEIGHT_BITS-1:0]    req_item_weight,
   input  logic [INDEX_BITS-1:0]     req_pick_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [ITEM_DATA_BITS-1:0] rsp_picked_data,
   output logic [WEIGHT_BITS-1:0]    rsp_taken_weight,
   output logic [TOTAL_BITS-1:0]     rsp_total_weight,
   output logic [HELD_BITS-1:0]      rsp_entries_held
);

   // Entry memory: one write and one registered read per cycle.
   logic [DATA_BITS-1:0]   mem_data_ff   [DEPTH];
   logic [WEIGHT_BITS-1:0] mem_weight_ff [DEPTH];

   // Latched request word.
   logic [FUNC_BITS-1:0]   op_ff;
   logic [DATA_BITS-1:0]   data_ff;
   logic [WEIGHT_BITS-1:0] wgt_ff;
   logic [INDEX_BITS-1:0]  idx_ff;

   // Scan state.
   logic [CNT_BITS-1:0]    ptr_ff,     ptr_in;
   logic [SUM_BITS-1:0]    running_ff, running_in;
   logic                   rd_vld_ff,  rd_vld_in;
   logic [ADDR_BITS-1:0]   rd_pos_ff;
   logic [DATA_BITS-1:0]   rd_data_ff;
   logic [WEIGHT_BITS-1:0] rd_wgt_ff;
   logic                   hit_ff;
   logic [DATA_BITS-1:0]   got_data_ff;
   logic [WEIGHT_BITS-1:0] got_wgt_ff;

   // Table totals.
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff,   sum_in;

   // Response register.
   logic                      rsp_valid_ff;
   logic [STATUS_BITS-1:0]    status_ff,  status_in;
   logic [ITEM_DATA_BITS-1:0] pdata_ff,   pdata_in;
   logic [WEIGHT_BITS-1:0]    pwgt_ff,    pwgt_in;
   logic [TOTAL_BITS-1:0]     total_ff,   total_in;
   logic [HELD_BITS-1:0]      held_ff,    held_in;

   logic                   rd_issue;
   logic [SUM_BITS-1:0]    running_sum;
   logic                   walk_hit;
   logic                   not_full;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [DATA_BITS-1:0]   wr_data;
   logic [WEIGHT_BITS-1:0] wr_wgt;

   assign rd_issue    = (cmd.walk || cmd.shift) && (ptr_ff < count_ff);
   assign running_sum = running_ff + SUM_BITS'(rd_wgt_ff);
   assign walk_hit    = rd_vld_ff && (CMP_BITS'(idx_ff) <= CMP_BITS'(running_sum));
   assign not_full    = (count_ff < CNT_BITS'(DEPTH));

   assign stat.walk_hit   = walk_hit;
   assign stat.walk_miss  = (ptr_ff >= count_ff) && !walk_hit;
   assign stat.shift_done = (ptr_ff >= count_ff) && !rd_vld_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Write port: shifting entries down, or appending at the end.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_pos_ff - ADDR_BITS'(1);
      wr_data = rd_data_ff;
      wr_wgt  = rd_wgt_ff;
      if (cmd.shift && rd_vld_ff) begin
         wr_en = 1'b1;
      end else if (cmd.finish && (op_ff == OP_APPEND) && not_full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[ADDR_BITS-1:0];
         wr_data = data_ff;
         wr_wgt  = wgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_data_ff[wr_addr]   <= wr_data;
         mem_weight_ff[wr_addr] <= wr_wgt;
      end
      rd_data_ff <= mem_data_ff[ptr_ff[ADDR_BITS-1:0]];
      rd_wgt_ff  <= mem_weight_ff[ptr_ff[ADDR_BITS-1:0]];
      rd_pos_ff  <= ptr_ff[ADDR_BITS-1:0];
   end

   // Scan pointer, read tracking and running sum.
   always_comb begin
      ptr_in     = ptr_ff;
      rd_vld_in  = rd_issue;
      running_in = running_ff;
      if (cmd.take) begin
         ptr_in     = '0;
         rd_vld_in  = 1'b0;
         running_in = '0;
      end else if (cmd.walk && walk_hit) begin
         // The shift starts at the entry right after the picked one.
         ptr_in    = CNT_BITS'(rd_pos_ff) + CNT_BITS'(1);
         rd_vld_in = 1'b0;
      end else begin
         if (rd_issue) begin
            ptr_in = ptr_ff + CNT_BITS'(1);
         end
         if (cmd.walk && rd_vld_ff) begin
            running_in = running_sum;
         end
      end
   end

   // Totals and response word at the end of an operation.
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      status_in = ST_OK;
      pdata_in  = '0;
      pwgt_in   = '0;
      case (op_ff)
         OP_APPEND: begin
            if (not_full) begin
               count_in = count_ff + CNT_BITS'(1);
               sum_in   = sum_ff + SUM_BITS'(wgt_ff);
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_PICK: begin
            if (hit_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               sum_in   = sum_ff - SUM_BITS'(got_wgt_ff);
               pdata_in = ITEM_DATA_BITS'(got_data_ff);
               pwgt_in  = got_wgt_ff;
            end else begin
               status_in = ST_NOMATCH;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            sum_in   = '0;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      total_in = (32'(sum_in) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum_in);
      held_in  = (32'(count_in) > 32'(HELD_MAX)) ? HELD_MAX : HELD_BITS'(count_in);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         running_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         running_ff <= running_in;
         rd_vld_ff  <= rd_vld_in;
         if (cmd.take) begin
            hit_ff <= 1'b0;
         end else if (cmd.walk && walk_hit) begin
            hit_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            sum_ff       <= sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_func;
         data_ff <= DATA_BITS'(req_item_data);
         wgt_ff  <= req_item_weight;
         idx_ff  <= req_pick_index;
      end
      if (cmd.walk && walk_hit) begin
         got_data_ff <= rd_data_ff;
         got_wgt_ff  <= rd_wgt_ff;
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         pdata_ff  <= pdata_in;
         pwgt_ff   <= pwgt_in;
         total_ff  <= total_in;
         held_ff   <= held_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_picked_data  = pdata_ff;
   assign rsp_taken_weight = pwgt_ff;
   assign rsp_total_weight = total_ff;
   assign rsp_entries_held = held_ff;

endmodule

>>> rtl/weighted_pick_and_remove_table.sv
// ============================================================================
// weighted_pick_and_remove_table: ordered table with weighted pick and removal
// Appends weighted entries, removes the first entry whose running weight sum
// reaches a given index while keeping the order of the rest, and clears.
// ============================================================================
//
//   Channel   Direction  Word contents
//   --------  ---------  ----------------------------------------------------
//   req_chan  in         func, item_data, item_weight, pick_index
//   rsp_chan  out        status, picked_data, taken_weight, total_weight,
//                        entries_held
//
// Append, clear and the unused code go from the accepting state straight to
// the done state, which loads the result register once it is free; the
// controller then returns to idle and takes the next word. A pick first
// scans the single read port of the entry memory one entry per cycle up to
// the match, and then each later entry is read and written one place down.
// Reset empties the table at once; the memory needs no clearing pass, since
// only entries below the count are ever read.
// A new word is taken once the previous one is in the result register, so
// one word can wait on rsp_chan while the next is being worked on; a stalled
// result holds the block only when the next result is ready to be loaded.
//
module weighted_pick_and_remove_table import wpt_pkg::*; (
   input logic  clock,
   input logic  reset,
   wpt_req_if.sink   req_chan,
   wpt_rsp_if.source rsp_chan
);

   wpt_cmd_type  cmd;
   wpt_stat_type stat;

   // The controller sequences one operation at a time.
   wpt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the entries, totals and the result register.
   wpt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_chan.func),
      .req_item_data    (req_chan.item_data),
      .req_item_weight  (req_chan.item_weight),
      .req_pick_index   (req_chan.pick_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_picked_data  (rsp_chan.picked_data),
      .rsp_taken_weight (rsp_chan.taken_weight),
      .rsp_total_weight (rsp_chan.total_weight),
      .rsp_entries_held (rsp_chan.entries_held)
   );

endmodule

>>> rtl/wpt_checker.sv
// ============================================================================
// wpt_checker: port-level checks for the weighted pick-and-remove table
// Watches the response channel for holding, reset and result consistency.
// ============================================================================
module wpt_checker import wpt_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STATUS_BITS-1:0]    rsp_status,
   input logic [ITEM_DATA_BITS-1:0] rsp_picked_data,
   input logic [WEIGHT_BITS-1:0]    rsp_taken_weight,
   input logic [TOTAL_BITS-1:0]     rsp_total_weight,
   input logic [HELD_BITS-1:0]      rsp_entries_held
);

   localparam int FULL_HELD = (DEPTH > 127) ? 127 : DEPTH;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_picked_data) && $stable(rsp_taken_weight)
         && $stable(rsp_total_weight) && $stable(rsp_entries_held))
      else $error("result word changed while stalled");

   // No result follows a reset cycle.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A full report means the table holds every entry it can.
   a_full_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> 32'(rsp_entries_held) == FULL_HELD)
      else $error("table full reported with free entries");

   // When the status is not OK, the removed-entry fields are zero.
   a_no_removal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_picked_data == '0)
         && (rsp_taken_weight == '0))
      else $error("removed-entry fields set without a removal");

   // Entry count never exceeds the table depth.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entries_held) <= FULL_HELD)
      else $error("entry count beyond table depth");

endmodule

bind weighted_pick_and_remove_table wpt_checker u_wpt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_picked_data  (rsp_chan.picked_data),
   .rsp_taken_weight (rsp_chan.taken_weight),
   .rsp_total_weight (rsp_chan.total_weight),
   .rsp_entries_held (rsp_chan.entries_held)
);
